>>> rtl/rgbm_pkg.sv
package rgbm_pkg;

  // Request codes carried in req_type.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_SCAN  = 2'd1;
  localparam logic [1:0] REQ_FRAME = 2'd2;

  // Color channel codes carried in color_channel.
  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // Three colors in each of the two scan halves.
  localparam int NUM_COLORS = 3;
  localparam int NUM_PLANES = 2 * NUM_COLORS;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] pixel_x;
    logic [4:0] pixel_y;
    logic [1:0] color_channel;
    logic [2:0] level;
  } req_t;

  typedef struct packed {
    logic       top_red;
    logic       top_green;
    logic       top_blue;
    logic       bottom_red;
    logic       bottom_green;
    logic       bottom_blue;
    logic [4:0] column;
    logic [3:0] row_select;
    logic       last_column;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_we;
    logic scan_rd;
    logic pixel_we;
    logic sweep_inc;
    logic sweep_clr;
    logic row_zero;
    logic row_next;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_end;
    logic sweep_last_col;
  } dp_stat_t;

endpackage

>>> rtl/rgbm_ctrl.sv
module rgbm_ctrl
  import rgbm_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic [1:0] req_type,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  assign take = start && !busy;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_we  = 1'b1;
        cmd.sweep_inc = 1'b1;
        if (stat.sweep_end) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          case (req_type)
            REQ_WRITE: cmd.pixel_we = 1'b1;
            REQ_SCAN:  state_next = ST_SCAN;
            REQ_FRAME: cmd.row_zero = 1'b1;
            default:   ;
          endcase
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.sweep_last_col) begin
          cmd.sweep_clr = 1'b1;
          state_next    = ST_FLUSH;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      ST_FLUSH: begin
        // The last column is written back in this cycle; the row moves on after it.
        cmd.row_next = 1'b1;
        state_next   = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      busy  <= 1'b1;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule

>>> rtl/rgbm_datapath.sv
module rgbm_datapath
  import rgbm_pkg::*;
#(
  parameter int PANEL_COLUMNS = 32,
  parameter int ROWS_PER_HALF = 16,
  parameter int LEVEL_BITS    = 3
) (
  input  logic     clk,
  input  logic     rst,
  input  req_t     req,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output result_t  result,
  output logic     strobe
);

  localparam int CW    = $clog2(PANEL_COLUMNS);
  localparam int RW    = $clog2(ROWS_PER_HALF);
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int WW    = 2 * LEVEL_BITS;

  logic [AW-1:0] sweep;
  logic [RW-1:0] row;

  logic          s1_valid;
  logic [CW-1:0] s1_col;
  logic          s1_last;
  logic [WW-1:0] rd_word [NUM_PLANES];

  logic [NUM_PLANES-1:0] bits;
  logic [WW-1:0]         wb_word [NUM_PLANES];

  logic                  pix_ok;
  logic                  pix_bottom;
  logic [RW-1:0]         pix_row;
  logic [AW-1:0]         pix_addr;
  logic [LEVEL_BITS-1:0] pix_level;
  logic [2:0]            pix_plane;

  assign stat.sweep_end      = (sweep == {AW{1'b1}});
  assign stat.sweep_last_col = (sweep[CW-1:0] == CW'(PANEL_COLUMNS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep <= '0;
      row   <= '0;
    end else begin
      if (cmd.sweep_clr) begin
        sweep <= '0;
      end else if (cmd.sweep_inc) begin
        sweep <= sweep + AW'(1);
      end
      if (cmd.row_zero) begin
        row <= '0;
      end else if (cmd.row_next) begin
        row <= (row == RW'(ROWS_PER_HALF - 1)) ? '0 : row + RW'(1);
      end
    end
  end

  // Pixel write decode.
  always_comb begin
    int yi;
    pix_ok     = (req.color_channel <= CH_BLUE) &&
                 (int'(req.pixel_x) < PANEL_COLUMNS) &&
                 (int'(req.pixel_y) < 2 * ROWS_PER_HALF);
    pix_bottom = (int'(req.pixel_y) >= ROWS_PER_HALF);
    yi         = int'(req.pixel_y) - (pix_bottom ? ROWS_PER_HALF : 0);
    pix_row    = RW'(yi);
    pix_addr   = {pix_row, CW'(req.pixel_x)};
    pix_level  = LEVEL_BITS'(req.level);
    pix_plane  = (pix_bottom ? 3'(NUM_COLORS) : 3'd0) + 3'(req.color_channel);
  end

  // PWM decision and counter update for the word read in the previous cycle.
  always_comb begin
    for (int m = 0; m < NUM_PLANES; m++) begin
      logic [LEVEL_BITS-1:0] lv;
      logic [LEVEL_BITS-1:0] ct;
      lv         = rd_word[m][WW-1:LEVEL_BITS];
      ct         = rd_word[m][LEVEL_BITS-1:0];
      bits[m]    = (ct != '0) && (ct <= lv);
      wb_word[m] = {lv, (lv != '0) ? ct - LEVEL_BITS'(1) : ct};
    end
  end

  for (genvar m = 0; m < NUM_PLANES; m++) begin : g_plane
    logic [WW-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (cmd.clear_we) begin
        mem[sweep] <= '0;
      end else if (cmd.pixel_we && pix_ok && (pix_plane == 3'(m))) begin
        mem[pix_addr] <= {pix_level, pix_level};
      end else if (s1_valid) begin
        mem[{row, s1_col}] <= wb_word[m];
      end
      if (cmd.scan_rd) begin
        rd_word[m] <= mem[{row, sweep[CW-1:0]}];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      strobe   <= 1'b0;
    end else begin
      s1_valid <= cmd.scan_rd;
      strobe   <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_col  <= sweep[CW-1:0];
    s1_last <= stat.sweep_last_col;
    if (s1_valid) begin
      result.top_red      <= bits[0];
      result.top_green    <= bits[1];
      result.top_blue     <= bits[2];
      result.bottom_red   <= bits[3];
      result.bottom_green <= bits[4];
      result.bottom_blue  <= bits[5];
      result.column       <= 5'(s1_col);
      result.row_select   <= 4'(row);
      result.last_column  <= s1_last;
    end
  end

endmodule

>>> rtl/rgb_matrix_row_scan_pwm.sv
// Scan item: after acceptance each column is read into rd_word in ST_SCAN, then registered
// into result with strobe, one beat per cycle; busy stays high until ST_FLUSH is done.
// Each color plane memory has one read port and one write port. Pixel writes and
// new-frame items are taken without raising busy and can follow each other in consecutive
// cycles. Reset: a clearing pass writes all 2^(clog2(ROWS_PER_HALF) + clog2(PANEL_COLUMNS))
// words of every plane memory (512 by default) with busy high. The receiver cannot stall.
module rgb_matrix_row_scan_pwm
  import rgbm_pkg::*;
#(
  parameter int PANEL_COLUMNS = 32,
  parameter int ROWS_PER_HALF = 16,
  parameter int LEVEL_BITS    = 3
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  req_t    req,
  output logic    busy,
  output result_t result,
  output logic    strobe
);

  // The controller sequences the reset clearing pass, the column sweep of a
  // scan and a flush in which the last column is written back.
  // The datapath holds the six color planes (red, green, blue for each scan
  // half), each word packing a level and its down-counter, plus the sweep
  // counter that serves both the clearing pass and the column index.

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rgbm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  // Each scan column is read in its scan cycle and, in the next, its bits are
  // formed and the decremented counters are written back to the same word.
  rgbm_datapath #(
    .PANEL_COLUMNS (PANEL_COLUMNS),
    .ROWS_PER_HALF (ROWS_PER_HALF),
    .LEVEL_BITS    (LEVEL_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cmd    (cmd),
    .stat   (stat),
    .result (result),
    .strobe (strobe)
  );

endmodule
